@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the buck converter step core
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// labelled assertion on an explicit clock and synchronous reset
`define BCES_ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// labelled assertion on the house clock and reset names
`define BCES_ASSERT(label, prop, msg) \
   `BCES_ASSERT_CLK(label, clock, reset, prop, msg)

`endif

@@ rtl/core/bces_pkg.sv @@
// ----------------------------------------------------------------------------
// bces_pkg
// types, constants and microcode table of the buck converter euler step core
// ----------------------------------------------------------------------------
package bces_pkg;

   // default fixed-point configuration
   localparam int FRAC_BITS_DEF = 24;
   localparam int DAC_BITS_DEF  = 12;

   // register and port widths
   localparam int VIN_W        = 31;
   localparam int COEF_W       = 24;
   localparam int DAC_SCALE_W  = 16;
   localparam int IL_W         = 32;
   localparam int REQ_TDATA_W  = 8;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 32;
   localparam int RSP_TDATA_W_DEF = ((2 * DAC_BITS_DEF + 7) / 8) * 8;

   // register reset values
   localparam logic [VIN_W-1:0]       VIN_RESET       = 31'd201326592;
   localparam logic [COEF_W-1:0]      STEP_L_RESET    = 24'd16777;
   localparam logic [COEF_W-1:0]      STEP_C_RESET    = 24'd1677722;
   localparam logic [COEF_W-1:0]      INV_LOAD_RESET  = 24'd1677722;
   localparam logic [DAC_SCALE_W-1:0] DAC_SCALE_RESET = 16'd58240;

   // register indexes of the configuration channel
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_INPUT_VOLTAGE         = 3'd0,
      CSR_STEP_OVER_INDUCTANCE  = 3'd1,
      CSR_STEP_OVER_CAPACITANCE = 3'd2,
      CSR_INVERSE_LOAD          = 3'd3,
      CSR_DAC_SCALE             = 3'd4
   } csr_index_type;

   // multiplier operand selects
   typedef enum logic [1:0] {
      MA_VOUT,
      MA_VL,
      MA_IC,
      MA_VCODE
   } mul_a_type;

   typedef enum logic [1:0] {
      MB_INV_LOAD,
      MB_STEP_L,
      MB_STEP_C,
      MB_DAC_SCALE
   } mul_b_type;

   // step advance condition
   typedef enum logic [1:0] {
      BR_NONE,
      BR_WAIT_REQ,
      BR_WAIT_RSP
   } branch_type;

   localparam int UPC_W = 4;
   typedef logic [UPC_W-1:0] upc_type;

   // microprogram addresses
   localparam upc_type UPC_IDLE  = 4'd0;
   localparam upc_type UPC_VL    = 4'd1;
   localparam upc_type UPC_IC    = 4'd2;
   localparam upc_type UPC_IL    = 4'd3;
   localparam upc_type UPC_VOUT  = 4'd4;
   localparam upc_type UPC_DAC   = 4'd5;
   localparam upc_type UPC_VCODE = 4'd6;
   localparam upc_type UPC_ICUR  = 4'd7;
   localparam upc_type UPC_OUT   = 4'd8;

   typedef struct packed {
      branch_type branch;
      upc_type    next_upc;
      logic       mul_en;
      mul_a_type  mul_a;
      mul_b_type  mul_b;
      logic       ld_vl;
      logic       ld_ic;
      logic       ld_il;
      logic       ld_vout;
      logic       ld_vcode;
      logic       ld_rsp;
   } uword_type;

   typedef struct packed {
      uword_type uword;
      logic      fire;
   } seq_ctrl_type;

   // microcode table: one control word per step
   function automatic uword_type ucode_rom(input upc_type upc);
      uword_type w;
      w = '0;
      w.branch   = BR_NONE;
      w.next_upc = UPC_IDLE;
      w.mul_a    = MA_VOUT;
      w.mul_b    = MB_INV_LOAD;
      case (upc)
         UPC_IDLE: begin
            w.branch   = BR_WAIT_REQ;
            w.next_upc = UPC_VL;
         end
         UPC_VL: begin
            // inductor voltage loaded; multiplier forms vout times inverse load
            w.ld_vl    = 1'b1;
            w.mul_en   = 1'b1;
            w.mul_a    = MA_VOUT;
            w.mul_b    = MB_INV_LOAD;
            w.next_upc = UPC_IC;
         end
         UPC_IC: begin
            // capacitor current loaded; multiplier forms inductor voltage times dt/L
            w.ld_ic    = 1'b1;
            w.mul_en   = 1'b1;
            w.mul_a    = MA_VL;
            w.mul_b    = MB_STEP_L;
            w.next_upc = UPC_IL;
         end
         UPC_IL: begin
            // new inductor current loaded; multiplier forms capacitor current times dt/C
            w.ld_il    = 1'b1;
            w.mul_en   = 1'b1;
            w.mul_a    = MA_IC;
            w.mul_b    = MB_STEP_C;
            w.next_upc = UPC_VOUT;
         end
         UPC_VOUT: begin
            w.ld_vout  = 1'b1;
            w.next_upc = UPC_DAC;
         end
         UPC_DAC: begin
            w.mul_en   = 1'b1;
            w.mul_a    = MA_VOUT;
            w.mul_b    = MB_DAC_SCALE;
            w.next_upc = UPC_VCODE;
         end
         UPC_VCODE: begin
            w.ld_vcode = 1'b1;
            w.next_upc = UPC_ICUR;
         end
         UPC_ICUR: begin
            w.mul_en   = 1'b1;
            w.mul_a    = MA_VCODE;
            w.mul_b    = MB_INV_LOAD;
            w.next_upc = UPC_OUT;
         end
         UPC_OUT: begin
            w.branch   = BR_WAIT_RSP;
            w.ld_rsp   = 1'b1;
            w.next_upc = UPC_IDLE;
         end
         default: begin
            w.next_upc = UPC_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

@@ rtl/core/bces_seq.sv @@
// ----------------------------------------------------------------------------
// bces_seq
// step counter and microcode table; issues one control word per cycle
// ----------------------------------------------------------------------------
module bces_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  rsp_free,
   output bces_pkg::seq_ctrl_type ctrl
);
   import bces_pkg::*;

   upc_type   upc_ff;
   upc_type   upc_in;
   uword_type uword;
   logic      fire;

   // decode current step and its advance condition
   always_comb begin
      uword = ucode_rom(upc_ff);
      case (uword.branch)
         BR_WAIT_REQ: fire = req_tvalid;
         BR_WAIT_RSP: fire = rsp_free;
         default:     fire = 1'b1;
      endcase
      upc_in = fire ? uword.next_upc : upc_ff;
   end

   assign ctrl.uword = uword;
   assign ctrl.fire  = fire;

   // step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= UPC_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

@@ rtl/core/buck_converter_euler_step_core.sv @@
// ----------------------------------------------------------------------------
// buck_converter_euler_step_core
// forward-euler model of an ideal buck converter, one step per input word
// ----------------------------------------------------------------------------
// Each accepted request word carries the switch state for one tick; the core
// advances inductor current and output voltage by one Q8.F euler step and
// returns one word with the voltage and load current DAC codes. A step is run
// by the microprogram that walks the single shared multiplier through its five
// products; the next request is taken the cycle after the result is loaded
// into the output register, even while that result still waits to be taken,
// so no new word is accepted while a step is still running.
// Configuration writes are taken every cycle and are meant for idle periods.
// ----------------------------------------------------------------------------
module buck_converter_euler_step_core #(
   parameter  int FRAC_BITS   = bces_pkg::FRAC_BITS_DEF,
   parameter  int DAC_BITS    = bces_pkg::DAC_BITS_DEF,
   localparam int RSP_TDATA_W = ((2 * DAC_BITS + 7) / 8) * 8
) (
   input  logic                             clock,
   input  logic                             reset,
   // request: [0] switch_closed, [7:1] zero
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [bces_pkg::REQ_TDATA_W-1:0] req_tdata,
   // response: [DAC_BITS-1:0] voltage_code, [2*DAC_BITS-1:DAC_BITS] current_code
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [RSP_TDATA_W-1:0]           rsp_tdata,
   // register write channel
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [bces_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bces_pkg::CSR_DATA_W-1:0]  csr_data
);
   import bces_pkg::*;

   // operand width covers the inductor voltage and the capacitor current
   localparam int A_W = (FRAC_BITS < 24) ? (57 - FRAC_BITS) : 33;
   localparam int B_W = COEF_W + 1;
   localparam int P_W = A_W + B_W;

   localparam logic [DAC_BITS-1:0] DAC_MAX = '1;
   localparam logic signed [P_W-1:0] DAC_MAX_P = P_W'(DAC_MAX);
   localparam logic signed [P_W-1:0] IL_MAX_P  = P_W'(signed'({1'b0, {(IL_W-1){1'b1}}}));
   localparam logic signed [P_W-1:0] IL_MIN_P  = P_W'(signed'({1'b1, {(IL_W-1){1'b0}}}));

   seq_ctrl_type ctrl;
   logic         rsp_free;

   // configuration registers
   logic [VIN_W-1:0]       vin_ff,       vin_in;
   logic [COEF_W-1:0]      step_l_ff,    step_l_in;
   logic [COEF_W-1:0]      step_c_ff,    step_c_in;
   logic [COEF_W-1:0]      inv_load_ff,  inv_load_in;
   logic [DAC_SCALE_W-1:0] dac_scale_ff, dac_scale_in;

   // converter state
   logic [VIN_W-1:0]       vout_ff, vout_in;
   logic signed [IL_W-1:0] il_ff,   il_in;

   // working registers
   logic                   sw_ff,    sw_in;
   logic signed [A_W-1:0]  vl_ff,    vl_in;
   logic signed [A_W-1:0]  ic_ff,    ic_in;
   logic [DAC_BITS-1:0]    vcode_ff, vcode_in;
   logic signed [P_W-1:0]  p_ff,     p_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff,  rsp_data_in;

   // datapath nets
   logic signed [A_W-1:0] mul_a;
   logic signed [B_W-1:0] mul_b;
   logic signed [P_W-1:0] prod;
   logic signed [P_W-1:0] sh;
   logic signed [P_W-1:0] vsh;
   logic signed [P_W-1:0] il_sum;
   logic signed [P_W-1:0] vout_sum;
   logic signed [P_W-1:0] vin_p;
   logic signed [A_W-1:0] vin_a;
   logic signed [A_W-1:0] vout_a;
   logic [DAC_BITS-1:0]   icode;
   logic                  go;

   bces_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .rsp_free   (rsp_free),
      .ctrl       (ctrl)
   );

   assign go         = ctrl.fire;
   assign req_tready = (ctrl.uword.branch == BR_WAIT_REQ);
   assign csr_ready  = 1'b1;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // shared multiplier operand selection
   always_comb begin
      case (ctrl.uword.mul_a)
         MA_VOUT:  mul_a = A_W'(signed'({1'b0, vout_ff}));
         MA_VL:    mul_a = vl_ff;
         MA_IC:    mul_a = ic_ff;
         MA_VCODE: mul_a = A_W'(signed'({1'b0, vcode_ff}));
         default:  mul_a = '0;
      endcase
      case (ctrl.uword.mul_b)
         MB_INV_LOAD:  mul_b = signed'({1'b0, inv_load_ff});
         MB_STEP_L:    mul_b = signed'({1'b0, step_l_ff});
         MB_STEP_C:    mul_b = signed'({1'b0, step_c_ff});
         MB_DAC_SCALE: mul_b = signed'(B_W'(dac_scale_ff));
         default:      mul_b = '0;
      endcase
   end

   assign prod = P_W'(mul_a) * P_W'(mul_b);

   // floor of the registered product by the fraction scaling
   assign sh     = p_ff >>> FRAC_BITS;
   assign vsh    = p_ff >>> (FRAC_BITS + 8);
   assign vin_a  = A_W'(signed'({1'b0, vin_ff}));
   assign vout_a = A_W'(signed'({1'b0, vout_ff}));
   assign vin_p  = P_W'(signed'({1'b0, vin_ff}));
   assign il_sum   = P_W'(il_ff) + sh;
   assign vout_sum = P_W'(signed'({1'b0, vout_ff})) + sh;
   assign icode    = (sh > DAC_MAX_P) ? DAC_MAX : sh[DAC_BITS-1:0];

   // next-state logic
   always_comb begin
      vin_in       = vin_ff;
      step_l_in    = step_l_ff;
      step_c_in    = step_c_ff;
      inv_load_in  = inv_load_ff;
      dac_scale_in = dac_scale_ff;
      vout_in      = vout_ff;
      il_in        = il_ff;
      sw_in        = sw_ff;
      vl_in        = vl_ff;
      ic_in        = ic_ff;
      vcode_in     = vcode_ff;
      p_in         = p_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      // register writes, upper bits dropped, unknown index ignored
      if (csr_valid) begin
         case (csr_index)
            CSR_INPUT_VOLTAGE:         vin_in       = csr_data[VIN_W-1:0];
            CSR_STEP_OVER_INDUCTANCE:  step_l_in    = csr_data[COEF_W-1:0];
            CSR_STEP_OVER_CAPACITANCE: step_c_in    = csr_data[COEF_W-1:0];
            CSR_INVERSE_LOAD:          inv_load_in  = csr_data[COEF_W-1:0];
            CSR_DAC_SCALE:             dac_scale_in = csr_data[DAC_SCALE_W-1:0];
            default: ;
         endcase
      end

      // switch state of the accepted word
      if (req_tvalid && req_tready) begin
         sw_in = req_tdata[0];
      end

      if (go && ctrl.uword.mul_en) begin
         p_in = prod;
      end

      // inductor voltage from the old output voltage
      if (go && ctrl.uword.ld_vl) begin
         vl_in = sw_ff ? (vin_a - vout_a) : -vout_a;
      end

      // capacitor current
      if (go && ctrl.uword.ld_ic) begin
         ic_in = A_W'(P_W'(il_ff) - sh);
      end

      // inductor current with saturation
      if (go && ctrl.uword.ld_il) begin
         if (il_sum > IL_MAX_P) begin
            il_in = IL_W'(IL_MAX_P);
         end else if (il_sum < IL_MIN_P) begin
            il_in = IL_W'(IL_MIN_P);
         end else begin
            il_in = il_sum[IL_W-1:0];
         end
      end

      // output voltage clamped to 0..vin
      if (go && ctrl.uword.ld_vout) begin
         if (vout_sum < 0) begin
            vout_in = '0;
         end else if (vout_sum > vin_p) begin
            vout_in = vin_ff;
         end else begin
            vout_in = vout_sum[VIN_W-1:0];
         end
      end

      // voltage code, truncated and clamped
      if (go && ctrl.uword.ld_vcode) begin
         vcode_in = (vsh > DAC_MAX_P) ? DAC_MAX : vsh[DAC_BITS-1:0];
      end

      // result word
      if (go && ctrl.uword.ld_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = RSP_TDATA_W'({icode, vcode_ff});
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control, configuration and converter state
   always_ff @(posedge clock) begin
      if (reset) begin
         vin_ff       <= VIN_RESET;
         step_l_ff    <= STEP_L_RESET;
         step_c_ff    <= STEP_C_RESET;
         inv_load_ff  <= INV_LOAD_RESET;
         dac_scale_ff <= DAC_SCALE_RESET;
         vout_ff      <= '0;
         il_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         vin_ff       <= vin_in;
         step_l_ff    <= step_l_in;
         step_c_ff    <= step_c_in;
         inv_load_ff  <= inv_load_in;
         dac_scale_ff <= dac_scale_in;
         vout_ff      <= vout_in;
         il_ff        <= il_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working payload registers
   always_ff @(posedge clock) begin
      sw_ff       <= sw_in;
      vl_ff       <= vl_in;
      ic_ff       <= ic_in;
      vcode_ff    <= vcode_in;
      p_ff        <= p_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

@@ rtl/core/bces_checker.sv @@
// ----------------------------------------------------------------------------
// bces_checker
// port-level assertions of the buck converter euler step core
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bces_checker #(
   parameter int RSP_TDATA_W = bces_pkg::RSP_TDATA_W_DEF
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);
   import bces_pkg::*;

   // one step in flight: no new word right after one is taken
   `BCES_ASSERT(a_one_word_in_flight, (req_tvalid && req_tready) |=> !req_tready, "request taken while a step is running")

   // a result cannot appear in the cycle after a request is taken
   `BCES_ASSERT(a_no_instant_result, (req_tvalid && req_tready) |=> !$rose(rsp_tvalid), "result offered too early")

   // a new result is loaded only at the end of a step, never while idle
   `BCES_ASSERT(a_result_from_step, $rose(rsp_tvalid) |-> !$past(req_tready), "result raised while waiting for a request")

   // stalled result word holds
   `BCES_ASSERT(a_rsp_hold, (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)), "stalled result changed")

endmodule

bind buck_converter_euler_step_core bces_checker #(
   .RSP_TDATA_W (RSP_TDATA_W)
) u_bces_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
